// ----- design/fpl_pkg.sv -----
// Shared constants, types and coefficient tables for the float power pipeline.
package fpl_pkg;

  localparam int unsigned FB = 24;
  localparam int unsigned NS = 43;
  localparam int unsigned DIV_N = 23;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DOM = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;
  localparam logic [1:0] ST_UNF = 2'd3;

  localparam logic [31:0] POW_RESET = 32'h3F80_0000;
  localparam logic [31:0] POS_INF   = 32'h7F80_0000;
  localparam logic [32:0] T_SAT     = 33'h1_0000_0000;
  localparam logic [32:0] T_HI      = 33'(128) << FB;
  localparam logic [32:0] T_LO      = 33'(126) << FB;
  localparam logic [25:0] TWO_LN2   = 26'd48408813;

  localparam logic [31:0] SER_INIT = 32'd1864135;
  localparam logic [31:0] SER_ADD [0:3] = '{32'd2396745, 32'd3355443, 32'd5592405, 32'd16777216};
  localparam logic [31:0] EXP_INIT = 32'd2592;
  localparam logic [31:0] EXP_ADD [0:5] = '{32'd22370, 32'd161365, 32'd931204,
                                            32'd4030340, 32'd11629077, 32'd16777216};

  typedef struct packed {
    logic [1:0]        sts;
    logic signed [9:0] e;
    logic [22:0]       m;
    logic [22:0]       z;
    logic [21:0]       z2;
    logic [25:0]       lm;
    logic              lneg;
    logic              magz;
    logic [33:0]       magl;
    logic [40:0]       pl;
    logic [40:0]       ph;
    logic [57:0]       prod;
    logic [32:0]       mag;
    logic              neg;
    logic [23:0]       f;
    logic [7:0]        biased;
    logic [31:0]       res;
  } side_t;

endpackage

// ----- design/fpl_div_cell.sv -----
// One restoring division step that produces one quotient bit per cycle while en_i is high.
module fpl_div_cell (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [24:0] rem_i,
  input  logic [24:0] div_i,
  input  logic [22:0] q_i,
  output logic [24:0] rem_o,
  output logic [22:0] q_o
);

  logic [25:0] r2;
  logic        ge;
  logic [25:0] diff;
  logic [24:0] rem_d;
  logic [22:0] q_d;

  always_comb begin
    r2    = {rem_i, 1'b0};
    diff  = r2 - {1'b0, div_i};
    ge    = r2 >= {1'b0, div_i};
    rem_d = ge ? diff[24:0] : r2[24:0];
    q_d   = {q_i[21:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      q_o   <= q_d;
    end
  end

endmodule

// ----- design/fpl_mac_cell.sv -----
// One Horner step of a fixed-point polynomial: truncated product plus coefficient.
module fpl_mac_cell (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] acc_i,
  input  logic [31:0] mul_i,
  input  logic [31:0] add_i,
  output logic [31:0] acc_o
);

  logic [63:0] prod;
  logic [31:0] acc_d;

  always_comb begin
    prod  = acc_i * mul_i;
    acc_d = 32'(prod >> fpl_pkg::FB) + add_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_o <= acc_d;
    end
  end

endmodule

// ----- design/float_power_log_exp.sv -----
// Top level: float32 x raised to a registered float32 power through log2 and exp2.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata[31:0] sample_bits
//  m_axis    out  m_axis_tvalid/tready       tdata[31:0] result_bits, [33:32] status
//  cfg       in   cfg_wr_en                  cfg_wr_data[31:0] exponent_bits
//
// One request enters per cycle unless a result waits at the output.
// The pipeline holds a row of 23 division cells, 10 Horner cells and the
// scaling stages. Reset clears the valid bits and sets the power to 1.0.
// When a result waits at the output the whole row holds and no request is
// taken until that result leaves.
module float_power_log_exp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] sample_bits
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] result_bits, [33:32] status
  input  logic        cfg_wr_en_i,
  input  logic [31:0] cfg_wr_data_i
);

  localparam int unsigned NS = fpl_pkg::NS;

  logic [31:0]     pow_q;
  logic [NS-1:0]   vld_q;
  logic            adv;
  fpl_pkg::side_t  side_q [0:NS-1];
  fpl_pkg::side_t  side_d [0:NS-1];

  logic [24:0] rem_w [0:fpl_pkg::DIV_N];
  logic [22:0] quo_w [0:fpl_pkg::DIV_N];
  logic [31:0] ser_w [0:4];
  logic [31:0] exp_w [0:6];

  logic [7:0]  pe;
  logic [22:0] pm;
  logic        psign;

  assign pe    = pow_q[30:23];
  assign pm    = pow_q[22:0];
  assign psign = pow_q[31];
  assign adv   = !vld_q[NS-1] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[NS-1];
  assign m_axis_tdata_o  = {6'b0, side_q[NS-1].sts, side_q[NS-1].res};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pow_q <= fpl_pkg::POW_RESET;
      vld_q <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        pow_q <= cfg_wr_data_i;
      end
      if (adv) begin
        vld_q <= {vld_q[NS-2:0], s_axis_tvalid_i};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NS; k++) begin
        side_q[k] <= side_d[k];
      end
    end
  end

  assign rem_w[0] = {1'b0, side_q[0].m, 1'b0};
  assign quo_w[0] = '0;

  for (genvar j = 1; j <= fpl_pkg::DIV_N; j++) begin : g_div
    fpl_div_cell u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .rem_i (rem_w[j-1]),
      .div_i ({2'b10, side_q[j-1].m}),
      .q_i   (quo_w[j-1]),
      .rem_o (rem_w[j]),
      .q_o   (quo_w[j])
    );
  end

  assign ser_w[0] = fpl_pkg::SER_INIT;
  for (genvar j = 0; j < 4; j++) begin : g_ser
    fpl_mac_cell u_mac (
      .clk_i (clk_i),
      .en_i  (adv),
      .acc_i (ser_w[j]),
      .mul_i ({10'b0, side_q[24+j].z2}),
      .add_i (fpl_pkg::SER_ADD[j]),
      .acc_o (ser_w[j+1])
    );
  end

  assign exp_w[0] = fpl_pkg::EXP_INIT;
  for (genvar j = 0; j < 6; j++) begin : g_exp
    fpl_mac_cell u_mac (
      .clk_i (clk_i),
      .en_i  (adv),
      .acc_i (exp_w[j]),
      .mul_i ({8'b0, side_q[35+j].f}),
      .add_i (fpl_pkg::EXP_ADD[j]),
      .acc_o (exp_w[j+1])
    );
  end

  always_comb begin
    logic [7:0]         xe;
    logic [22:0]        xm;
    logic [4:0]         sh;
    logic [45:0]        zz;
    logic [54:0]        p29;
    logic [51:0]        p30;
    logic signed [34:0] lg;
    logic [23:0]        pmant;
    logic [7:0]         pe_eff;
    logic signed [9:0]  kk;
    logic [7:0]         r;
    logic [63:0]        rnd;
    logic [96:0]        wide;
    logic [63:0]        mg;
    logic signed [33:0] t;
    logic [9:0]         ip;
    logic [24:0]        mant;
    logic [8:0]         bx;

    xe = s_axis_tdata_i[30:23];
    xm = s_axis_tdata_i[22:0];
    sh = '0;
    for (int i = 0; i < 23; i++) begin
      if (xm[i]) sh = 5'(23 - i);
    end

    side_d[0] = '0;
    if (s_axis_tdata_i[31] || xe == 8'hFF || (xe == 8'h00 && xm == '0) ||
        (pe == 8'hFF && pm != '0)) begin
      side_d[0].sts = fpl_pkg::ST_DOM;
    end
    if (xe == 8'h00) begin
      side_d[0].e = -10'sd126 - $signed({5'b0, sh});
      side_d[0].m = 23'(xm << sh);
    end else begin
      side_d[0].e = $signed({2'b0, xe}) - 10'sd127;
      side_d[0].m = xm;
    end

    for (int k = 1; k < NS; k++) begin
      side_d[k] = side_q[k-1];
    end

    zz = quo_w[23] * quo_w[23];
    side_d[24].z  = quo_w[23];
    side_d[24].z2 = 22'(zz >> fpl_pkg::FB);

    p29 = {9'b0, side_q[28].z} * ser_w[4];
    side_d[29].lm = 26'(p29 >> fpl_pkg::FB);

    p30 = side_q[29].lm * fpl_pkg::TWO_LN2;
    side_d[30].lm = 26'(p30 >> fpl_pkg::FB);

    lg = 35'($signed({side_q[30].e, 24'b0})) + $signed({9'b0, side_q[30].lm});
    side_d[31].lneg = lg[34];
    side_d[31].magl = lg[34] ? 34'(-lg) : lg[33:0];

    pmant = (pe == 8'h00) ? {1'b0, pm} : {1'b1, pm};
    side_d[32].pl   = side_q[31].magl[16:0] * pmant;
    side_d[32].ph   = side_q[31].magl[33:17] * pmant;
    side_d[32].magz = side_q[31].magl == '0;

    side_d[33].prod = ({17'b0, side_q[32].ph} << 17) + {17'b0, side_q[32].pl};

    pe_eff = (pe == 8'h00) ? 8'd1 : pe;
    kk     = $signed({2'b0, pe_eff}) - 10'sd150;
    r      = 8'(-kk);
    rnd    = '0;
    wide   = '0;
    mg     = '0;
    if (pe == 8'hFF) begin
      mg = side_q[33].magz ? 64'd0 : 64'(fpl_pkg::T_SAT);
    end else if (kk < 0) begin
      if (r < 8'd63) begin
        rnd = {6'b0, side_q[33].prod} + (64'd1 << (r - 8'd1));
        mg  = rnd >> r;
      end
    end else if (side_q[33].prod == '0) begin
      mg = '0;
    end else if (kk >= 10'sd40) begin
      mg = 64'(fpl_pkg::T_SAT);
    end else begin
      wide = {39'b0, side_q[33].prod} << kk[5:0];
      mg   = (wide > 97'(fpl_pkg::T_SAT)) ? 64'(fpl_pkg::T_SAT) : wide[63:0];
    end
    if (mg > 64'(fpl_pkg::T_SAT)) begin
      mg = 64'(fpl_pkg::T_SAT);
    end
    side_d[34].mag = mg[32:0];
    side_d[34].neg = side_q[33].lneg != psign;

    t  = side_q[34].neg ? -$signed({1'b0, side_q[34].mag}) : $signed({1'b0, side_q[34].mag});
    ip = t[33:24];
    side_d[35].f      = t[23:0];
    side_d[35].biased = 8'(ip + 10'd127);
    if (side_q[34].sts == fpl_pkg::ST_OK) begin
      if (!side_q[34].neg && side_q[34].mag >= fpl_pkg::T_HI) begin
        side_d[35].sts = fpl_pkg::ST_OVF;
      end else if (side_q[34].neg && side_q[34].mag > fpl_pkg::T_LO) begin
        side_d[35].sts = fpl_pkg::ST_UNF;
      end
    end

    mant = 25'((exp_w[6] + 32'd1) >> 1);
    bx   = {1'b0, side_q[41].biased};
    if (mant[24]) begin
      mant = mant >> 1;
      bx   = bx + 9'd1;
    end
    side_d[42].res = '0;
    if (side_q[41].sts == fpl_pkg::ST_OK) begin
      if (bx >= 9'd255) begin
        side_d[42].sts = fpl_pkg::ST_OVF;
        side_d[42].res = fpl_pkg::POS_INF;
      end else begin
        side_d[42].res = {1'b0, bx[7:0], mant[22:0]};
      end
    end else if (side_q[41].sts == fpl_pkg::ST_OVF) begin
      side_d[42].res = fpl_pkg::POS_INF;
    end
  end

`ifndef SYNTHESIS
  a_ovf_inf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[33:32] == fpl_pkg::ST_OVF
    |-> m_axis_tdata_o[31:0] == fpl_pkg::POS_INF)
    else $error("overflow status without infinity");
  a_ok_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[33:32] == fpl_pkg::ST_OK
    |-> !m_axis_tdata_o[31] && m_axis_tdata_o[30:23] != 8'h00 && m_axis_tdata_o[30:23] != 8'hFF)
    else $error("ok result is not a positive normal number");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved during a stall");
  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[33:32] == fpl_pkg::ST_DOM ||
                        m_axis_tdata_o[33:32] == fpl_pkg::ST_UNF)
    |-> m_axis_tdata_o[31:0] == 32'h0)
    else $error("flagged result is not zero");
`endif

endmodule

// ----- dv/fpl_checker.sv -----
// Checker for the float power block: predicts each result and compares the output stream.
`timescale 1ns / 100ps
module fpl_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [31:0] s_data_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [39:0] m_data_i,
  input  logic        cfg_en_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o
);

  logic [31:0] power_q;
  logic [33:0] expected_q[$];

  function automatic longint unsigned recip(longint unsigned d);
    return ((64'd1 << fpl_pkg::FB) + d / 2) / d;
  endfunction

  function automatic longint unsigned from_q30(longint unsigned c);
    return ((c << fpl_pkg::FB) + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint log2_fixed(logic [7:0] bexp, logic [31:0] mant_in);
    longint unsigned z, z2, s, lm;
    logic [31:0] mant;
    int e, sh;
    mant = mant_in;
    sh = 0;
    if (bexp == 0) begin
      while (mant[23] == 1'b0 && sh < 24) begin
        mant = mant << 1;
        sh++;
      end
      mant = mant & 32'h007F_FFFF;
      e = -126 - sh;
    end else begin
      e = int'(bexp) - 127;
    end
    z = (longint'(mant) << fpl_pkg::FB) / (64'h0100_0000 + longint'(mant));
    z2 = (z * z) >> fpl_pkg::FB;
    s = recip(9);
    s = ((s * z2) >> fpl_pkg::FB) + recip(7);
    s = ((s * z2) >> fpl_pkg::FB) + recip(5);
    s = ((s * z2) >> fpl_pkg::FB) + recip(3);
    s = ((s * z2) >> fpl_pkg::FB) + (64'd1 << fpl_pkg::FB);
    lm = (z * s) >> fpl_pkg::FB;
    lm = (lm * from_q30(64'd3098164009)) >> fpl_pkg::FB;
    return longint'(e) * longint'(64'd1 << fpl_pkg::FB) + longint'(lm);
  endfunction

  // Returns {status, result_bits}.
  function automatic logic [33:0] pow_predict(logic [31:0] x, logic [31:0] pw);
    longint unsigned coef[7];
    longint unsigned magl, mag, u, f, poly, mant, pmant, prod, tsat;
    longint lg, t, ip;
    logic [7:0] xe, pe;
    logic [22:0] xm, pm;
    int k, r, biased;
    coef = '{165915, 1431684, 10327388, 59597074, 257941777, 744260924, 1073741824};
    tsat = 64'd256 << fpl_pkg::FB;
    xe = x[30:23];
    xm = x[22:0];
    pe = pw[30:23];
    pm = pw[22:0];
    if (x[31] || xe == 8'hFF || (xe == 0 && xm == 0) || (pe == 8'hFF && pm != 0))
      return {fpl_pkg::ST_DOM, 32'd0};
    lg = log2_fixed(xe, {9'd0, xm});
    magl = lg < 0 ? longint'(-lg) : longint'(lg);
    if (pe == 8'hFF) begin
      mag = magl == 0 ? 0 : tsat;
    end else begin
      pmant = pe == 0 ? longint'(pm) : longint'({1'b1, pm});
      prod = magl * pmant;
      k = (pe == 0 ? 1 : int'(pe)) - 150;
      if (k < 0) begin
        r = -k;
        mag = r >= 63 ? 0 : ((prod + (64'd1 << (r - 1))) >> r);
      end else if (prod == 0) begin
        mag = 0;
      end else if (k >= 40 || prod > (tsat >> k)) begin
        mag = tsat;
      end else begin
        mag = prod << k;
      end
    end
    if (mag > tsat) mag = tsat;
    t = ((lg < 0) != pw[31]) ? -longint'(mag) : longint'(mag);
    if (t >= longint'(128) * longint'(64'd1 << fpl_pkg::FB))
      return {fpl_pkg::ST_OVF, fpl_pkg::POS_INF};
    if (t < -longint'(126) * longint'(64'd1 << fpl_pkg::FB))
      return {fpl_pkg::ST_UNF, 32'd0};
    u = longint'(t + longint'(tsat));
    ip = longint'(u >> fpl_pkg::FB) - 256;
    f = u & ((64'd1 << fpl_pkg::FB) - 1);
    poly = from_q30(coef[0]);
    for (k = 1; k < 7; k++) poly = ((poly * f) >> fpl_pkg::FB) + from_q30(coef[k]);
    mant = (poly + 1) >> 1;
    biased = int'(ip) + 127;
    if (mant >= (64'd1 << 24)) begin
      mant = mant >> 1;
      biased++;
    end
    if (biased >= 255) return {fpl_pkg::ST_OVF, fpl_pkg::POS_INF};
    return {fpl_pkg::ST_OK, biased[8:0], mant[22:0]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [33:0] want;
    if (!rst_ni) begin
      power_q <= fpl_pkg::POW_RESET;
      fail_count_o <= 0;
      results_o <= 0;
    end else begin
      if (cfg_en_i) power_q <= cfg_data_i;
      if (s_valid_i && s_ready_i) expected_q.push_back(pow_predict(s_data_i, power_q));
      if (m_valid_i && m_ready_i) begin
        results_o <= results_o + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_data_i[33:0]);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want[31:0] !== m_data_i[31:0] || want[33:32] !== m_data_i[33:32]) begin
            $display("%0t: result mismatch expected %h status %0d, actual %h status %0d",
                     $time, want[31:0], want[33:32], m_data_i[31:0], m_data_i[33:32]);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = expected_q.size();

endmodule

// ----- dv/tb_float_power_log_exp.sv -----
// Testbench top for the float power block: stimulus, power settings and the verdict.
`timescale 1ns / 100ps
module tb_float_power_log_exp;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [31:0] s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [39:0] m_data;
  logic        cfg_en = 1'b0;
  logic [31:0] cfg_data = '0;
  int          fail_count, pending, results;
  int          send_idle = 33, recv_idle = 48;
  int          requests = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  float_power_log_exp dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_o(m_data),
    .cfg_wr_en_i(cfg_en), .cfg_wr_data_i(cfg_data)
  );

  fpl_checker checker_i (
    .clk_i, .rst_ni,
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_data_i(s_data),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data),
    .cfg_en_i(cfg_en), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results)
  );

  always @(posedge clk_i) begin
    m_ready <= $urandom_range(0, 99) >= recv_idle;
  end

  task automatic send_sample(logic [31:0] x);
    if ($urandom_range(0, 99) < send_idle) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= x;
    @(posedge clk_i iff (s_valid && s_ready));
    requests++;
    if (requests == 220) begin
      send_idle = 48;
      recv_idle = 33;
    end else if (requests == 440) begin
      send_idle = 0;
      recv_idle = 0;
    end
  endtask

  // The power may only change once the pipeline has drained.
  task automatic set_power(logic [31:0] pw);
    s_valid <= 1'b0;
    @(posedge clk_i iff (pending == 0));
    repeat (50) @(posedge clk_i);
    cfg_en <= 1'b1;
    cfg_data <= pw;
    @(posedge clk_i);
    cfg_en <= 1'b0;
  endtask

  function automatic logic [31:0] random_sample();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return {9'd0, 23'($urandom())};
      default: return {1'b0, 8'($urandom_range(90, 165)), 23'($urandom())};
    endcase
  endfunction

  function automatic logic [31:0] random_power();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return {1'($urandom()), 8'($urandom_range(100, 127)), 23'($urandom())};
      default: return {1'($urandom()), 8'($urandom_range(110, 133)), 23'($urandom())};
    endcase
  endfunction

  initial begin
    logic [31:0] edge_samples[13];
    logic [31:0] edge_powers[14];
    edge_samples = '{32'h0000_0000, 32'h8000_0000, 32'hC000_0000, 32'h7F80_0000,
                     32'h7FC0_0000, 32'h0000_0001, 32'h007F_FFFF, 32'h0080_0000,
                     32'h7F7F_FFFF, 32'h3F80_0000, 32'h4000_0000, 32'h3F00_0000,
                     32'h3FFF_FFFF};
    edge_powers = '{32'h3F80_0000, 32'h0000_0000, 32'hBF80_0000, 32'h3F00_0000,
                    32'h7F7F_FFFF, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
                    32'h0000_0001, 32'h8000_0000, 32'h4120_0000, 32'hC060_0000,
                    32'hFFFF_FFFF, 32'h4040_0000};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (edge_samples[i]) send_sample(edge_samples[i]);
    foreach (edge_powers[j]) begin
      set_power(edge_powers[j]);
      for (int i = 0; i < 8; i++) send_sample(edge_samples[$urandom_range(0, 12)]);
      for (int i = 0; i < 22; i++) send_sample(random_sample());
    end
    for (int j = 0; j < 6; j++) begin
      set_power(random_power());
      for (int i = 0; i < 40; i++) send_sample(random_sample());
    end
    s_valid <= 1'b0;
    @(posedge clk_i iff (pending == 0));
    repeat (60) @(posedge clk_i);
    $display("Sent %0d samples over %0d power settings, including domain, overflow,",
             requests, 21);
    $display("underflow, subnormal and infinite cases; %0d results compared.", results);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/fpl_pkg.sv
design/fpl_div_cell.sv
design/fpl_mac_cell.sv
design/float_power_log_exp.sv
dv/fpl_checker.sv
dv/tb_float_power_log_exp.sv
